// File: design/jof_pkg.sv
// Shared types and constants for the JSON object framer.
`timescale 1ns / 1ps

package jof_pkg;

   localparam int unsigned LEN_W = 13;

   localparam logic [7:0] CHAR_OPEN   = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE  = 8'h7D;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;

   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 13'd1024;

   typedef enum logic {
      KIND_DATA  = 1'b0,
      KIND_RESET = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       frame_start;
      logic       frame_end;
      logic       frame_abort;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] depth;
      logic             in_frame;
      logic             in_quote;
      logic             escape_pending;
      logic [LEN_W-1:0] frame_length;
   } frame_state_type;

endpackage

// File: design/jof_step.sv
// Per-byte framing step: context tracking, brace depth, length check and result.
`timescale 1ns / 1ps

module jof_step (
   input  jof_pkg::req_type               req,
   input  jof_pkg::frame_state_type       state,
   input  logic [jof_pkg::LEN_W-1:0]      max_length,
   output jof_pkg::frame_state_type       state_next,
   output logic                           emit,
   output jof_pkg::rsp_type               rsp
);

   always_comb begin
      jof_pkg::frame_state_type s;
      logic                     start;
      logic                     done;
      logic [7:0]               c;

      s          = state;
      start      = 1'b0;
      done       = 1'b0;
      c          = req.byte_in;
      emit       = 1'b0;
      rsp        = '0;
      state_next = state;

      if (req.kind == jof_pkg::KIND_RESET) begin
         // A reset request clears everything and reports a frame that was open.
         state_next      = '0;
         emit            = state.in_frame;
         rsp.frame_abort = 1'b1;
      end else begin
         if (s.escape_pending) begin
            s.escape_pending = 1'b0;
         end else if (s.in_quote) begin
            if (c == jof_pkg::CHAR_BSLASH) begin
               s.escape_pending = 1'b1;
            end else if (c == jof_pkg::CHAR_QUOTE) begin
               s.in_quote = 1'b0;
            end
         end else if (c == jof_pkg::CHAR_QUOTE) begin
            s.in_quote = 1'b1;
         end else if (c == jof_pkg::CHAR_OPEN) begin
            if (s.depth == '0) begin
               s.frame_length = '0;
               s.in_frame     = 1'b1;
               start          = 1'b1;
            end
            s.depth = s.depth + 13'd1;
         end

         if (!s.in_frame) begin
            state_next = s;
         end else if ({1'b0, s.frame_length} + 14'd1 > {1'b0, max_length}) begin
            // The frame would grow past the limit, so it is dropped.
            state_next      = '0;
            emit            = 1'b1;
            rsp.frame_abort = 1'b1;
         end else begin
            s.frame_length = s.frame_length + 13'd1;
            if (c == jof_pkg::CHAR_CLOSE && !s.in_quote) begin
               if (s.depth <= 13'd1) begin
                  s.depth        = '0;
                  s.in_frame     = 1'b0;
                  s.frame_length = '0;
                  done           = 1'b1;
               end else begin
                  s.depth = s.depth - 13'd1;
               end
            end
            state_next      = s;
            emit            = 1'b1;
            rsp.byte_out    = c;
            rsp.frame_start = start;
            rsp.frame_end   = done;
         end
      end
   end

endmodule

// File: design/json_object_framer_top.sv
// Top level of the JSON object framer: request register, framing state and result register.
`timescale 1ns / 1ps

// The framer takes one request per clock cycle; each accepted request passes through the
// request register and then the result register before its result is handed out. The
// per-byte work is a single pass of flag and counter updates on the framing
// state, so a request follows every cycle as long as rsp_ready stays high; a stall on the
// result side backs up into req_ready through the request register. A data request gives
// one result if its byte falls inside a frame (an opening brace at depth zero outside a
// string starts one), and no result otherwise. A reset request gives an abort result only
// when a frame was open. A frame that would grow longer than max_length bytes is aborted
// and all framing state is cleared. max_length is written through the csr_ channel, which
// is always ready; it resets to 1024 and should be changed only while the block is idle.

module json_object_framer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  jof_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output jof_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [jof_pkg::LEN_W-1:0]    csr_data
);

   // Request register.
   logic                      in_valid_ff;
   logic                      in_valid_in;
   jof_pkg::req_type          in_data_ff;

   // Framing state and configuration.
   jof_pkg::frame_state_type  state_ff;
   jof_pkg::frame_state_type  state_in;
   logic [jof_pkg::LEN_W-1:0] max_length_ff;
   logic [jof_pkg::LEN_W-1:0] max_length_in;

   // Result register.
   logic                      out_valid_ff;
   logic                      out_valid_in;
   jof_pkg::rsp_type          out_data_ff;

   // Step outputs.
   jof_pkg::frame_state_type  step_state;
   logic                      step_emit;
   jof_pkg::rsp_type          step_rsp;

   logic                      advance;

   // The held request moves on once the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   jof_step u_step (
      .req        (in_data_ff),
      .state      (state_ff),
      .max_length (max_length_ff),
      .state_next (step_state),
      .emit       (step_emit),
      .rsp        (step_rsp)
   );

   always_comb begin
      in_valid_in   = req_ready ? req_valid : in_valid_ff;
      state_in      = advance ? step_state : state_ff;
      max_length_in = (csr_valid && csr_ready) ? csr_data : max_length_ff;
      if (advance) begin
         out_valid_in = step_emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= '0;
         max_length_ff <= jof_pkg::MAX_LENGTH_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         state_ff      <= state_in;
         max_length_ff <= max_length_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance && step_emit) begin
         out_data_ff <= step_rsp;
      end
   end

endmodule

// File: design/jof_checker.sv
// Port-level checks for the JSON object framer and their binding to the top level.
`timescale 1ns / 1ps

module jof_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input jof_pkg::req_type             req_data,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input jof_pkg::rsp_type             rsp_data,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic [jof_pkg::LEN_W-1:0]    csr_data
);

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // An abort carries no byte and no frame marks.
   a_abort_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_abort |->
         rsp_data.byte_out == 8'h00 && !rsp_data.frame_start && !rsp_data.frame_end)
      else $error("abort result carries data");

   // A frame opens on an opening brace.
   a_start_brace: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_start |-> rsp_data.byte_out == jof_pkg::CHAR_OPEN)
      else $error("frame start on a byte other than an opening brace");

   // A frame closes on a closing brace.
   a_end_brace: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |->
         rsp_data.byte_out == jof_pkg::CHAR_CLOSE && !rsp_data.frame_abort)
      else $error("frame end on a byte other than a closing brace");

   // Nothing is presented right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind json_object_framer_top jof_checker u_jof_checker (.*);
